FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Every check is sampled on clk_i and
// is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/jsed_pkg.sv
`default_nettype none

package jsed_pkg;

  localparam int BufDepth = 6;
  localparam int CntW     = 3;

  localparam logic [7:0] Backslash = 8'h5c;
  localparam logic [7:0] UAdjLimit = 8'h5f;
  localparam logic [7:0] UAdjAdd   = 8'h20;
  localparam logic [7:0] OctSplit  = "3";

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_last;
  } in_t;

  typedef struct packed {
    logic [7:0] decoded_byte;
    logic       run_last;
    logic       message_end;
  } out_t;

  typedef logic [BufDepth-1:0][7:0] buf_t;

  // Outcome of one resolution step at the head of the lookahead buffer.
  typedef struct packed {
    logic            ok;
    logic [7:0]      val;
    logic [CntW-1:0] used;
  } res_t;

  function automatic logic is_hex(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] hex_val(logic [7:0] c);
    logic [3:0] v;
    if (c >= "0" && c <= "9") begin
      v = c[3:0];
    end else if (is_hex(c)) begin
      // The low nibble of a through f (either case) is 1 to 6.
      v = c[3:0] + 4'd9;
    end else begin
      v = 4'd0;
    end
    return v;
  endfunction

  function automatic logic is_oct(logic [7:0] c);
    return c >= "0" && c <= "7";
  endfunction

  function automatic logic is_f(logic [7:0] c);
    return c == "f" || c == "F";
  endfunction

  // Resolve one token at the head of b, which holds n valid bytes (n >= 1).
  // ok low means the escape must wait for more bytes.
  function automatic res_t resolve(buf_t b, logic [CntW-1:0] n, logic last);
    res_t            r;
    logic [7:0]      c;
    logic [7:0]      v;
    logic [7:0]      hi;
    logic [7:0]      lo;
    logic            is_u;
    logic [CntW-1:0] need;
    logic            all_hex;
    logic            o2;
    logic            o3;
    logic [1:0]      j;
    r.ok   = 1'b0;
    r.val  = b[0];
    r.used = CntW'(1);
    c      = b[1];
    is_u   = (c == "u");
    need   = is_u ? CntW'(6) : CntW'(4);
    hi     = is_u ? b[4] : b[2];
    lo     = is_u ? b[5] : b[3];
    all_hex = 1'b1;
    for (int k = 2; k < BufDepth; k++) begin
      if (CntW'(k) < need && CntW'(k) < n && !is_hex(b[k])) begin
        all_hex = 1'b0;
      end
    end
    o2 = (n > CntW'(2)) && is_oct(b[2]);
    o3 = o2 && (n > CntW'(3)) && is_oct(b[3]);
    j  = o3 ? 2'd3 : (o2 ? 2'd2 : 2'd1);
    v  = 8'd0;

    if (b[0] != Backslash) begin
      r.ok = 1'b1;
    end else if (n < CntW'(2)) begin
      // A lone backslash only resolves when the message ends.
      r.ok  = last;
      r.val = Backslash;
    end else if (c == "u" || c == "x") begin
      if (all_hex && n >= need) begin
        v = {hex_val(hi), hex_val(lo)};
        if (is_u && v != 8'd0 && v < UAdjLimit && is_f(b[2]) && is_f(b[3])) begin
          v = v + UAdjAdd;
        end
        r.ok   = 1'b1;
        r.val  = v;
        r.used = need;
      end else if (all_hex && !last) begin
        r.ok = 1'b0;
      end else begin
        // Broken form: emit the letter and rescan what follows it.
        r.ok   = 1'b1;
        r.val  = c;
        r.used = CntW'(2);
      end
    end else if (is_oct(c)) begin
      r.ok = o3 || (CntW'(j) + CntW'(1) < n) || last;
      if (o3 && c > OctSplit) begin
        j = 2'd2;
      end
      case (j)
        2'd1:    v = {5'd0, c[2:0]};
        2'd2:    v = {2'd0, c[2:0], b[2][2:0]};
        default: v = {c[1:0], b[2][2:0], b[3][2:0]};
      endcase
      r.val  = v;
      r.used = CntW'(j) + CntW'(1);
    end else begin
      r.ok   = 1'b1;
      r.used = CntW'(2);
      case (c)
        "a":     r.val = 8'h07;
        "b":     r.val = 8'h08;
        "f":     r.val = 8'h0c;
        "n":     r.val = 8'h0a;
        "r":     r.val = 8'h0d;
        "t":     r.val = 8'h09;
        "v":     r.val = 8'h0b;
        default: r.val = c;
      endcase
    end
    return r;
  endfunction

  // Remove k bytes from the front of the buffer.
  function automatic buf_t drop_front(buf_t b, logic [CntW-1:0] k);
    buf_t       r;
    logic [3:0] idx;
    for (int i = 0; i < BufDepth; i++) begin
      idx = 4'(i) + {1'b0, k};
      r[i] = (idx < 4'(BufDepth)) ? b[idx[CntW-1:0]] : 8'd0;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/js_escape_decoder_unit.sv
// Channel | Direction | Handshake              | Payload
// in      | input     | in_valid_i/in_ready_o  | in_data_i  (data_byte, message_last)
// out     | output    | out_valid_o/out_ready_i| out_data_o (decoded_byte, run_last, message_end)
//
// An item that yields zero or one decoded byte leaves in_ready_o high, so plain bytes stream at
// one per cycle while the output does not stall. An item that yields more bytes holds in_ready_o
// low until its last byte is registered, as one token is resolved per cycle when the output accepts.
// Reset clears the byte count, the busy flag, the message flag and the result valid.
// A stalled output blocks new items only when the result register cannot be refilled.
`default_nettype none
`include "assert_macros.svh"

module js_escape_decoder_unit (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  jsed_pkg::in_t        in_data_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output jsed_pkg::out_t       out_data_o
);
  import jsed_pkg::*;

  buf_t            buf_q, buf_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            last_q, last_d;
  logic            out_valid_q, out_valid_d;
  out_t            out_q, out_d;

  buf_t            src;
  buf_t            rem;
  logic [CntW-1:0] src_n;
  logic [CntW-1:0] rem_n;
  logic            src_last;
  logic            adv;
  logic            step;
  logic            more;
  res_t            head_res;
  res_t            next_res;

  always_comb begin
    // The result register can take a new value this cycle.
    adv        = !out_valid_q || out_ready_i;
    in_ready_o = !busy_q && adv;
    step       = busy_q ? adv : (in_valid_i && in_ready_o);

    src = buf_q;
    if (busy_q) begin
      src_n    = cnt_q;
      src_last = last_q;
    end else begin
      src[cnt_q] = in_data_i.data_byte;
      src_n      = cnt_q + CntW'(1);
      src_last   = in_data_i.message_last;
    end

    head_res = resolve(src, src_n, src_last);
    rem      = drop_front(src, head_res.used);
    rem_n    = src_n - head_res.used;
    // Look one token ahead so the item's last result carries its marker.
    next_res = resolve(rem, rem_n, src_last);
    more     = (rem_n != '0) && next_res.ok;

    buf_d       = buf_q;
    cnt_d       = cnt_q;
    busy_d      = busy_q;
    last_d      = last_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (step) begin
      if (head_res.ok) begin
        buf_d              = rem;
        cnt_d              = rem_n;
        busy_d             = more;
        last_d             = src_last;
        out_d.decoded_byte = head_res.val;
        out_d.run_last     = !more;
        out_d.message_end  = !more && src_last;
        out_valid_d        = 1'b1;
      end else begin
        // The escape is still incomplete: keep the new byte and wait.
        buf_d  = src;
        cnt_d  = src_n;
        busy_d = 1'b0;
        last_d = src_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      busy_q      <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      busy_q      <= busy_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_ALWAYS(a_busy_has_result, !busy_q || out_valid_q, "busy without a pending result")
  `ASSERT_ALWAYS(a_idle_head_escape, busy_q || cnt_q == '0 || buf_q[0] == Backslash,
                 "idle buffer does not start with an escape")
  `ASSERT_ALWAYS(a_end_empties_buffer,
                 !(out_valid_q && out_q.message_end) || (!busy_q && cnt_q == '0),
                 "message end while bytes remain buffered")

endmodule

`default_nettype wire

FILE: bench/testbench.sv
module testbench;
  import jsed_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 20;
  localparam int ItemsPerPhase = 75;

  // Tracks the lookahead buffer of the decoder and the decoded bytes still owed.
  class decoded_byte_board;
    localparam int MaxRes = 6;

    logic [7:0]  pend [BufDepth];
    int unsigned pend_n;
    out_t        decoded_q [$];
    int unsigned errors;

    function new();
      pend_n = 0;
      errors = 0;
    endfunction

    static function bit is_hex_char(logic [7:0] c);
      return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    static function logic [3:0] hex_digit(logic [7:0] c);
      if (c <= "9") return 4'(c - "0");
      if (c >= "a") return 4'(c - "a" + 10);
      return 4'(c - "A" + 10);
    endfunction

    static function bit is_oct_char(logic [7:0] c);
      return c >= "0" && c <= "7";
    endfunction

    function void drop(int unsigned k);
      if (k >= pend_n) begin
        pend_n = 0;
      end else begin
        for (int i = 0; i < pend_n - k; i++) pend[i] = pend[i + k];
        pend_n = pend_n - k;
      end
    endfunction

    // Resolves the escape at the head of the buffer. Returns the bytes it
    // consumes, or zero when it has to wait for more input.
    function int unsigned take_escape(bit last, output logic [7:0] o);
      logic [7:0]  c;
      logic [7:0]  v;
      int unsigned need;
      int unsigned lim;
      int unsigned j;
      bit          ok;
      bit          high_ff;
      o = Backslash;
      if (pend_n < 2) return last ? 1 : 0;
      c = pend[1];
      if (c == "u" || c == "x") begin
        need = (c == "u") ? 6 : 4;
        lim = (pend_n < need) ? pend_n : need;
        ok = 1'b1;
        for (int k = 2; k < lim; k++) begin
          if (!is_hex_char(pend[k])) ok = 1'b0;
        end
        if (ok && pend_n >= need) begin
          v = {hex_digit(pend[need - 2]), hex_digit(pend[need - 1])};
          high_ff = (pend[2] == "f" || pend[2] == "F") && (pend[3] == "f" || pend[3] == "F");
          if (c == "u" && v != 8'h00 && v < UAdjLimit && high_ff) v = v + UAdjAdd;
          o = v;
          return need;
        end
        if (ok && !last) return 0;
        o = c;
        return 2;
      end
      if (is_oct_char(c)) begin
        j = 0;
        while (j < 3 && 1 + j < pend_n && is_oct_char(pend[1 + j])) j++;
        if (!(j == 3 || 1 + j < pend_n || last)) return 0;
        // A first digit above three would overflow a byte, so it takes only two.
        if (j == 3 && c > OctSplit) j = 2;
        v = 8'h00;
        for (int k = 0; k < j; k++) v = {v[4:0], pend[1 + k][2:0]};
        o = v;
        return 1 + j;
      end
      case (c)
        "a": o = 8'h07;
        "b": o = 8'h08;
        "f": o = 8'h0c;
        "n": o = 8'h0a;
        "r": o = 8'h0d;
        "t": o = 8'h09;
        "v": o = 8'h0b;
        default: o = c;
      endcase
      return 2;
    endfunction

    function void note_input(in_t item);
      logic [7:0]  got [$];
      logic [7:0]  o;
      int unsigned used;
      out_t        r;
      bit          stuck;
      if (pend_n < BufDepth) begin
        pend[pend_n] = item.data_byte;
        pend_n++;
      end
      stuck = 1'b0;
      while (!stuck && pend_n > 0 && got.size() < MaxRes) begin
        if (pend[0] != Backslash) begin
          got.push_back(pend[0]);
          drop(1);
        end else begin
          used = take_escape(item.message_last, o);
          if (used == 0) begin
            stuck = 1'b1;
          end else begin
            got.push_back(o);
            drop(used);
          end
        end
      end
      foreach (got[k]) begin
        r.decoded_byte = got[k];
        r.run_last = (k == got.size() - 1);
        r.message_end = r.run_last && item.message_last;
        decoded_q.push_back(r);
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch: %s", what);
      errors++;
    endtask

    task check_result(out_t r);
      out_t e;
      if (decoded_q.size() == 0) begin
        report_mismatch($sformatf("byte %h arrived with nothing outstanding", r.decoded_byte));
        return;
      end
      e = decoded_q.pop_front();
      if (r.decoded_byte !== e.decoded_byte) begin
        report_mismatch($sformatf("decoded_byte %h, wanted %h", r.decoded_byte, e.decoded_byte));
      end
      if (r.run_last !== e.run_last) begin
        report_mismatch($sformatf("run_last %b, wanted %b (byte %h)", r.run_last, e.run_last,
                                  e.decoded_byte));
      end
      if (r.message_end !== e.message_end) begin
        report_mismatch($sformatf("message_end %b, wanted %b (byte %h)", r.message_end,
                                  e.message_end, e.decoded_byte));
      end
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_data_o;

  decoded_byte_board board;
  logic [7:0]        msg_q [$];
  int                idle_pct;
  int                stall_pct;
  int                items_sent;
  int                cycles;

  js_escape_decoder_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) board.note_input(in_data_i);
      if (out_valid_o && out_ready_i) board.check_result(out_data_o);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_byte(logic [7:0] b, logic flag_end);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i.data_byte <= b;
    in_data_i.message_last <= flag_end;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit flag_end);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], flag_end && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_hex();
    string digits;
    digits = "0123456789abcdefABCDEF";
    return digits[$urandom_range(0, 21)];
  endfunction

  function automatic logic [7:0] rand_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (decoded_byte_board::is_hex_char(c));
    return c;
  endfunction

  function automatic logic [7:0] rand_oct();
    return 8'("0" + $urandom_range(0, 7));
  endfunction

  task automatic add_token();
    string ctrl_letters;
    bit    is_u;
    int    n;
    ctrl_letters = "abfnrtv";
    case ($urandom_range(0, 11))
      0, 1, 2: msg_q.push_back(8'($urandom_range(0, 255)));
      3: begin
        msg_q.push_back(Backslash);
        msg_q.push_back("u");
        if ($urandom_range(0, 1)) begin
          msg_q.push_back($urandom_range(0, 1) ? "f" : "F");
          msg_q.push_back($urandom_range(0, 1) ? "f" : "F");
        end else begin
          msg_q.push_back(rand_hex());
          msg_q.push_back(rand_hex());
        end
        msg_q.push_back(rand_hex());
        msg_q.push_back(rand_hex());
      end
      4: begin
        msg_q.push_back(Backslash);
        msg_q.push_back("x");
        msg_q.push_back(rand_hex());
        msg_q.push_back(rand_hex());
      end
      5: begin
        msg_q.push_back(Backslash);
        n = $urandom_range(1, 3);
        repeat (n) msg_q.push_back(rand_oct());
      end
      6: begin
        msg_q.push_back(Backslash);
        msg_q.push_back(ctrl_letters[$urandom_range(0, 6)]);
      end
      7: begin
        msg_q.push_back(Backslash);
        msg_q.push_back(8'($urandom_range(0, 255)));
      end
      8: begin
        // Hex form broken by a stray character partway through.
        msg_q.push_back(Backslash);
        is_u = $urandom_range(0, 1);
        msg_q.push_back(is_u ? "u" : "x");
        n = $urandom_range(0, is_u ? 3 : 1);
        repeat (n) msg_q.push_back(rand_hex());
        msg_q.push_back(rand_non_hex());
      end
      9: begin
        msg_q.push_back(Backslash);
        msg_q.push_back(8'("4" + $urandom_range(0, 3)));
        msg_q.push_back(rand_oct());
        msg_q.push_back(rand_oct());
      end
      default: msg_q.push_back(8'("a" + $urandom_range(0, 25)));
    endcase
  endtask

  task automatic send_random_message();
    int n;
    bit flag_end;
    n = $urandom_range(1, 5);
    repeat (n) add_token();
    // Sometimes the message stops in the middle of an escape.
    case ($urandom_range(0, 7))
      0: msg_q.push_back(Backslash);
      1: begin
        msg_q.push_back(Backslash);
        msg_q.push_back($urandom_range(0, 1) ? "u" : "x");
        repeat ($urandom_range(0, 2)) msg_q.push_back(rand_hex());
      end
      2: begin
        msg_q.push_back(Backslash);
        msg_q.push_back(rand_oct());
      end
      default: ;
    endcase
    flag_end = ($urandom_range(0, 5) != 0);
    foreach (msg_q[i]) send_byte(msg_q[i], flag_end && i == msg_q.size() - 1);
    msg_q.delete();
  endtask

  initial begin
    int base;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    items_sent = 0;
    cycles = 0;
    board = new();
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);          // end flag with nothing buffered
    send_text("\\uFf21", 1'b1);      // high digits FF with the byte in range
    send_text("\\xG", 1'b1);         // non-hex digit in a hex form
    send_text("\\u1", 1'b1);         // message ends inside a hex form
    send_text("\\477", 1'b1);        // first digit above three: two digits only
    send_text("\\12", 1'b1);         // octal run cut by the end of the message
    send_text("\\n", 1'b1);
    send_text("\\", 1'b1);           // lone trailing backslash

    base = items_sent;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      while (items_sent - base < ItemsPerPhase * (phase + 1)) send_random_message();
    end
    in_valid_i <= 1'b0;
    idle_pct = 0;
    stall_pct = 0;

    while (board.decoded_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

FILE: js_escape_decoder_unit.f
+incdir+rtl
rtl/jsed_pkg.sv
rtl/js_escape_decoder_unit.sv
bench/testbench.sv
